@@ hdl/srbs_pkg.sv @@
// Shared types, constants and helper functions for the sensor rotation
// backoff scheduler. No dependencies; used by every module under hdl/.
package srbs_pkg;

  localparam int unsigned NumSens = 5;
  localparam int unsigned SensIdxW = 3;
  localparam logic [SensIdxW-1:0] HeartbeatIdx = 3'd4;
  localparam int unsigned CycleW = 32;
  localparam int unsigned RemCntW = $clog2(CycleW);

  localparam logic [7:0]  PeriodReset = 8'd30;
  localparam logic [15:0] YieldCapReset = 16'd20;
  localparam logic [7:0]  CeilingReset = 8'd16;
  localparam logic [6:0]  BatteryReset = 7'd100;
  localparam logic [6:0]  BatteryFull = 7'd100;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    CMD_NEXT   = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_EPOCH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD   = 2'd0,
    CFG_YIELDCAP = 2'd1,
    CFG_CEILING  = 2'd2,
    CFG_BATTERY  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REM,
    ST_FINISH
  } state_e;

  // request into the shared remainder unit
  typedef struct packed {
    logic              start;
    logic [CycleW-1:0] dividend;
    logic [7:0]        divisor;
  } rem_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] rem;
  } rem_rsp_t;

  // delay = 5 * (100 + floor(5 * (100 - p) / 2)), p forced to at least 1
  function automatic logic [10:0] delay_of(input logic [6:0] pct);
    logic [6:0] p;
    logic [6:0] d;
    logic [8:0] d5;
    logic [8:0] m;
    logic [10:0] res;
    p   = (pct == 7'd0) ? 7'd1 : pct;
    d   = BatteryFull - p;
    d5  = {2'b00, d} + {d, 2'b00};
    m   = 9'd100 + {1'b0, d5[8:1]};
    res = {2'b00, m} + {m, 2'b00};
    return res;
  endfunction

endpackage

@@ hdl/sensor_rotation_backoff_scheduler.sv @@
// Top level of the sensor rotation backoff scheduler: sensor tables,
// sequencer and output register. Depends on srbs_pkg and srbs_rem.
//
// Usage:
//  - Requests come in on s_axis (cmd, sensor_id, found); each request gives
//    exactly one result on m_axis (granted_sensor, sensor_capped, delay_ms).
//  - Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//    no request is in flight.
//  - A next request runs cycle_count mod heartbeat_period through the shared
//    32-step restoring remainder unit; the grant is registered when the unit
//    signals done, and the block takes the next request only after the
//    result has been loaded into the output register.
//  - Report, new-epoch and unused commands skip the remainder unit and go
//    straight to the finish state, which loads the output register when free.
//  - s_axis_tready is high only while the sequencer is idle; one request is
//    worked on at a time.
//  - The result sits in an output register; a request may be accepted while
//    it waits. If the receiver stalls, the next result holds in the
//    sequencer until the register empties.
//  - Reset clears the cycle count and all sensor tables and loads the
//    register defaults (period 30, cap 20, ceiling 16, battery 100).
module sensor_rotation_backoff_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [1:0] cmd, [4:2] sensor_id, [5] found, [7:6] zero
  input  logic [7:0]                     s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] granted_sensor, [3] sensor_capped, [14:4] delay_ms, [15] zero
  output logic [15:0]                    m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [srbs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [srbs_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int unsigned N = srbs_pkg::NumSens;
  localparam int unsigned IW = srbs_pkg::SensIdxW;

  srbs_pkg::state_e state_q, state_d;

  logic [7:0]  period_q;
  logic [15:0] cap_q;
  logic [7:0]  ceil_q;
  logic [6:0]  batt_q;

  logic [srbs_pkg::CycleW-1:0] cycle_q, cycle_nxt;
  logic [2:0]  mod5_q, mod5_nxt;
  logic [7:0]  backoff_q [N];
  logic [7:0]  skip_q [N];
  logic [15:0] yield_q [N];

  srbs_pkg::cmd_e cmd_q, in_cmd;
  logic [IW-1:0]  id_q, in_id;
  logic           in_found;
  logic [IW-1:0]  grant_q, grant_d;

  logic           out_valid_q;
  logic [15:0]    out_data_q;

  logic accept, out_load, out_free;
  srbs_pkg::rem_req_t rem_req;
  srbs_pkg::rem_rsp_t rem_rsp;

  assign in_cmd   = srbs_pkg::cmd_e'(s_axis_tdata[1:0]);
  assign in_id    = s_axis_tdata[4:2];
  assign in_found = s_axis_tdata[5];

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srbs_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (in_cmd == srbs_pkg::CMD_NEXT) ? srbs_pkg::ST_REM
                                                   : srbs_pkg::ST_FINISH;
        end
      end
      srbs_pkg::ST_REM: begin
        if (rem_rsp.done) state_d = srbs_pkg::ST_FINISH;
      end
      srbs_pkg::ST_FINISH: begin
        if (out_free) state_d = srbs_pkg::ST_IDLE;
      end
      default: state_d = srbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      srbs_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      srbs_pkg::ST_REM:    ;
      srbs_pkg::ST_FINISH: out_load = out_free;
      default:             ;
    endcase
  end

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // ---------------- shared remainder unit ----------------
  assign cycle_nxt        = cycle_q + 1'b1;
  assign rem_req.start    = accept && (in_cmd == srbs_pkg::CMD_NEXT);
  assign rem_req.dividend = cycle_nxt;
  assign rem_req.divisor  = period_q;

  srbs_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  // cycle mod 5 tracked alongside the count; 2^32 is not a multiple of 5
  always_comb begin
    if (cycle_q == '1) begin
      mod5_nxt = 3'd0;
    end else if (mod5_q == 3'd4) begin
      mod5_nxt = 3'd0;
    end else begin
      mod5_nxt = mod5_q + 1'b1;
    end
  end

  // ---------------- grant selection ----------------
  logic [N-1:0] capped, can_run;
  logic         scan_hit;
  logic [IW-1:0] scan_pick, best;
  logic [8:0]   min_skip;
  logic [3:0]   k;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      capped[i]  = (i >= 1) && (i <= 3) && (yield_q[i] >= cap_q);
      can_run[i] = !capped[i] && (skip_q[i] == 8'd0);
    end
  end

  always_comb begin
    scan_hit  = 1'b0;
    scan_pick = '0;
    k         = '0;
    for (int i = 0; i < N; i++) begin
      k = {1'b0, mod5_q} + 4'(i);
      if (k >= 4'(N)) k = k - 4'(N);
      if (!scan_hit && (k[IW-1:0] != srbs_pkg::HeartbeatIdx) && can_run[k[IW-1:0]]) begin
        scan_hit  = 1'b1;
        scan_pick = k[IW-1:0];
      end
    end
  end

  // fallback: uncapped non-heartbeat sensor with fewest skips, lowest index on ties
  always_comb begin
    best     = '0;
    min_skip = 9'h100;
    for (int i = 0; i < int'(srbs_pkg::HeartbeatIdx); i++) begin
      if (!capped[i] && ({1'b0, skip_q[i]} < min_skip)) begin
        min_skip = {1'b0, skip_q[i]};
        best     = IW'(i);
      end
    end
  end

  always_comb begin
    priority if ((period_q != 8'd0) && (rem_rsp.rem == 8'd0)) begin
      grant_d = srbs_pkg::HeartbeatIdx;
    end else if (scan_hit) begin
      grant_d = scan_pick;
    end else begin
      grant_d = best;
    end
  end

  // ---------------- report update ----------------
  logic [IW-1:0] rid;
  logic          rid_ok;
  logic [7:0]    b_cur, b_new;
  logic [8:0]    b_dbl;

  assign rid_ok = (in_id < IW'(N));
  assign rid    = rid_ok ? in_id : '0;
  assign b_cur  = backoff_q[rid];
  assign b_dbl  = {b_cur, 1'b0};

  always_comb begin
    priority if (b_cur == 8'd0) begin
      b_new = 8'd1;
    end else if (b_cur < ceil_q) begin
      b_new = (b_dbl > {1'b0, ceil_q}) ? ceil_q : b_dbl[7:0];
    end else begin
      b_new = b_cur;
    end
  end

  // ---------------- state registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srbs_pkg::ST_IDLE;
      cycle_q <= '0;
      mod5_q  <= '0;
      for (int i = 0; i < N; i++) begin
        backoff_q[i] <= '0;
        skip_q[i]    <= '0;
        yield_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (accept) begin
        unique case (in_cmd)
          srbs_pkg::CMD_NEXT: begin
            cycle_q <= cycle_nxt;
            mod5_q  <= mod5_nxt;
            for (int i = 0; i < N; i++) begin
              if (skip_q[i] != 8'd0) skip_q[i] <= skip_q[i] - 1'b1;
            end
          end
          srbs_pkg::CMD_REPORT: begin
            if (rid_ok) begin
              if (in_found) begin
                if (yield_q[rid] != 16'hFFFF) yield_q[rid] <= yield_q[rid] + 1'b1;
                backoff_q[rid] <= '0;
                skip_q[rid]    <= '0;
              end else begin
                backoff_q[rid] <= b_new;
                skip_q[rid]    <= b_new;
              end
            end
          end
          srbs_pkg::CMD_EPOCH: begin
            for (int i = 0; i < N; i++) begin
              yield_q[i] <= '0;
              if ((i >= 1) && (i <= 3)) begin
                backoff_q[i] <= '0;
                skip_q[i]    <= '0;
              end
            end
          end
          srbs_pkg::CMD_NONE: ;
          default: ;
        endcase
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= srbs_pkg::PeriodReset;
      cap_q    <= srbs_pkg::YieldCapReset;
      ceil_q   <= srbs_pkg::CeilingReset;
      batt_q   <= srbs_pkg::BatteryReset;
    end else if (cfg_we_i) begin
      unique case (srbs_pkg::cfg_idx_e'(cfg_idx_i))
        srbs_pkg::CFG_PERIOD:   period_q <= cfg_wdata_i[7:0];
        srbs_pkg::CFG_YIELDCAP: cap_q    <= cfg_wdata_i;
        srbs_pkg::CFG_CEILING:  ceil_q   <= cfg_wdata_i[7:0];
        srbs_pkg::CFG_BATTERY: begin
          batt_q <= (cfg_wdata_i[6:0] > srbs_pkg::BatteryFull) ? srbs_pkg::BatteryFull
                                                               : cfg_wdata_i[6:0];
        end
        default: ;
      endcase
    end
  end

  // request fields held for the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_cmd;
      id_q  <= in_id;
    end
    if (accept) begin
      grant_q <= '0;
    end else if ((state_q == srbs_pkg::ST_REM) && rem_rsp.done) begin
      grant_q <= grant_d;
    end
  end

  // ---------------- output register ----------------
  logic res_capped;
  assign res_capped = (id_q >= IW'(1)) && (id_q <= IW'(3)) && capped[id_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {1'b0, srbs_pkg::delay_of(batt_q), res_capped, grant_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  a_mod5_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod5_q < 3'd5)
    else $error("cycle mod 5 tracker out of range");
  a_rem_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_rsp.done |-> (state_q == srbs_pkg::ST_REM))
    else $error("remainder result arrived outside the wait state");
  a_grant_only_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (cmd_q != srbs_pkg::CMD_NEXT)) |=> (m_axis_tdata[2:0] == 3'd0))
    else $error("grant given for a command other than next");
  for (genvar g = 0; g < N; g++) begin : g_skip_chk
    a_skip_le_backoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
      skip_q[g] <= backoff_q[g])
      else $error("skip count above backoff level");
  end
`endif

endmodule

@@ hdl/srbs_rem.sv @@
// Shared remainder unit: restoring division, one dividend bit per cycle.
// Depends on srbs_pkg.
module srbs_rem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srbs_pkg::rem_req_t req_i,
  output srbs_pkg::rem_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [srbs_pkg::RemCntW-1:0]  cnt_q, cnt_d;
  logic [srbs_pkg::CycleW-1:0]   dvd_q, dvd_d;
  logic [7:0]                    dvs_q, dvs_d;
  logic [7:0]                    rem_q, rem_d;
  logic [8:0]                    trial;

  assign trial = {rem_q, dvd_q[srbs_pkg::CycleW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 8'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[7:0];
      end
      dvd_d = {dvd_q[srbs_pkg::CycleW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("remainder unit restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("remainder done without a running division");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("remainder done held for more than one cycle");
`endif

endmodule
